>>> src/multiword_divide_by_word_macros.svh
// Assertion macros for the multiword divide-by-word block.
// Used by multiword_divide_by_word.sv; needs signals clock and reset in scope.
`ifndef MULTIWORD_DIVIDE_BY_WORD_MACROS_SVH
`define MULTIWORD_DIVIDE_BY_WORD_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high.
`define MDW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge.
`define MDW_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> src/mdw_pkg.sv
// Shared constants and types for the multiword divide-by-word block.
// No dependencies.
package mdw_pkg;

   localparam int unsigned LIMB_BITS  = 64;
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned CNT_W      = $clog2(LIMB_BITS);
   localparam int unsigned RSP_DATA_W = 3 * WORD_BITS;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;

   // Register index, taken from byte address bit 3 (8-byte spacing).
   localparam logic REG_DIVISOR = 1'b0;

   localparam logic [WORD_BITS-1:0] DIVISOR_RESET = WORD_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

>>> src/multiword_divide_by_word.sv
// Short division of a multiword number by the 64-bit divisor register.
// Depends on mdw_pkg.sv and multiword_divide_by_word_macros.svh.
//
//  channel | direction | tdata (low bit up)                     | tlast      | tuser
//  req     | in        | limb                                   | final_limb | negative
//  rsp     | out       | quotient_limb, remainder_out, modulus  | last_out   | quotient_negative
//  csr     | in/out    | APB, divisor at byte address 0         | -          | -
//
// A request is taken only in idle, so each is divided fully before the next: accept in idle,
// one restoring step per limb bit in the divide state (64 steps, each a 65-bit subtract on the
// running remainder), then the finish state forms the modulus and loads the output register.
// Synchronous active-high reset: running remainder 0, divisor 1, no response held.
// A stalled response holds in the output register; the next request is still
// accepted and divided, and waits in the finish cycle until the register frees.
`include "multiword_divide_by_word_macros.svh"

module multiword_divide_by_word (
   input  logic                                 clock,
   input  logic                                 reset,
   // requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mdw_pkg::WORD_BITS-1:0]        req_tdata,  // [63:0] limb
   input  logic                                 req_tlast,  // final_limb
   input  logic                                 req_tuser,  // negative
   // responses
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [63:0] quotient_limb, [127:64] remainder_out, [191:128] modulus_out
   output logic [mdw_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,  // last_out
   output logic                                 rsp_tuser,  // quotient_negative
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mdw_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mdw_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mdw_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int unsigned LB = mdw_pkg::LIMB_BITS;
   localparam int unsigned WB = mdw_pkg::WORD_BITS;
   localparam int unsigned CW = mdw_pkg::CNT_W;

   mdw_pkg::state_type state_ff, state_in;

   logic [WB-1:0] divisor_ff, divisor_in;
   logic [WB-1:0] rem_ff, rem_in;
   logic [LB-1:0] limb_ff, limb_in;
   logic [LB-1:0] quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic          neg_ff, neg_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0] rsp_quot_ff, rsp_quot_in;
   logic [WB-1:0] rsp_rem_ff, rsp_rem_in;
   logic [WB-1:0] rsp_mod_ff, rsp_mod_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_neg_ff, rsp_neg_in;

   logic          req_accept;
   logic          out_load;
   logic          csr_write;
   logic [WB-1:0] shifted;
   logic [WB:0]   diff;
   logic          take;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      divisor_in = divisor_ff;
      if (csr_write && (csr_paddr[3] == mdw_pkg::REG_DIVISOR)) begin
         divisor_in = csr_pwdata[WB-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[3] == mdw_pkg::REG_DIVISOR) begin
         csr_prdata = mdw_pkg::CSR_DATA_W'(divisor_ff);
      end
   end

   // ---------------- control ----------------
   always_comb begin
      req_tready = (state_ff == mdw_pkg::ST_IDLE);
      req_accept = req_tvalid && req_tready;
      out_load   = (state_ff == mdw_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mdw_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = mdw_pkg::ST_DIVIDE;
            end
         end
         mdw_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = mdw_pkg::ST_FINISH;
            end
         end
         mdw_pkg::ST_FINISH: begin
            if (out_load) begin
               state_in = mdw_pkg::ST_IDLE;
            end
         end
         default: state_in = mdw_pkg::ST_IDLE;
      endcase
   end

   // ---------------- restoring divider, one quotient bit per cycle ----------------
   // Carry out of the remainder's top bit forces a subtract: the partial value
   // then is at least 2^64 and is surely above the divisor.
   always_comb begin
      shifted = {rem_ff[WB-2:0], limb_ff[LB-1]};
      diff    = {1'b0, shifted} - {1'b0, divisor_ff};
      take    = rem_ff[WB-1] || !diff[WB];
   end

   always_comb begin
      rem_in  = rem_ff;
      limb_in = limb_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      neg_in  = neg_ff;
      if (req_accept) begin
         limb_in = req_tdata[LB-1:0];
         quot_in = '0;
         cnt_in  = CW'(LB - 1);
         last_in = req_tlast;
         neg_in  = req_tuser;
      end else if (state_ff == mdw_pkg::ST_DIVIDE) begin
         rem_in  = take ? diff[WB-1:0] : shifted;
         limb_in = {limb_ff[LB-2:0], 1'b0};
         quot_in = {quot_ff[LB-2:0], take};
         cnt_in  = cnt_ff - CW'(1);
      end else if (out_load && last_ff) begin
         rem_in = '0;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_quot_in  = rsp_quot_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_mod_in   = rsp_mod_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_neg_in   = rsp_neg_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_quot_in  = WB'(quot_ff);
         rsp_last_in  = last_ff;
         rsp_neg_in   = neg_ff;
         rsp_rem_in   = '0;
         rsp_mod_in   = '0;
         if (last_ff) begin
            rsp_rem_in = rem_ff;
            rsp_mod_in = (neg_ff && (rem_ff != '0)) ? (divisor_ff - rem_ff) : rem_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mod_ff, rsp_rem_ff, rsp_quot_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_neg_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdw_pkg::ST_IDLE;
         divisor_ff   <= mdw_pkg::DIVISOR_RESET;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         divisor_ff   <= divisor_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limb_ff     <= limb_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      neg_ff      <= neg_in;
      rsp_quot_ff <= rsp_quot_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_mod_ff  <= rsp_mod_in;
      rsp_last_ff <= rsp_last_in;
      rsp_neg_ff  <= rsp_neg_in;
   end

   // ---------------- assertions ----------------
   `MDW_ASSERT(a_accept_starts_divide, req_accept |=> (state_ff == mdw_pkg::ST_DIVIDE) && (cnt_ff == CW'(LB - 1)), "request accepted but divider not started")
   `MDW_ASSERT(a_last_clears_rem, (out_load && last_ff) |=> (rem_ff == '0), "running remainder not cleared after last limb")
   `MDW_ASSERT(a_load_returns_idle, out_load |=> (state_ff == mdw_pkg::ST_IDLE) && rsp_tvalid, "response load did not return to idle")
   `MDW_NEVER(a_rem_only_on_last, rsp_tvalid && !rsp_tlast && ((rsp_rem_ff != '0) || (rsp_mod_ff != '0)), "remainder fields nonzero on a limb that is not last")

endmodule

>>> dv/tb_multiword_divide_by_word.sv
// Stream-level test of multiword_divide_by_word: limbs go in, and each quotient limb,
// remainder and modulus is checked against a bit-serial restoring divide in the bench.
// Depends on mdw_pkg.sv and the multiword_divide_by_word RTL.
module tb;

   localparam int unsigned WORD_BITS  = mdw_pkg::WORD_BITS;
   localparam int unsigned LIMB_BITS  = mdw_pkg::LIMB_BITS;
   localparam int unsigned RSP_DATA_W = mdw_pkg::RSP_DATA_W;
   localparam int unsigned CSR_ADDR_W = mdw_pkg::CSR_ADDR_W;
   localparam int unsigned CSR_DATA_W = mdw_pkg::CSR_DATA_W;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES   = 80;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam logic [WORD_BITS-1:0] LIMB_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LIMB_BITS);
   localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] TOP_BIT   = WORD_BITS'(1) << (WORD_BITS - 1);
   localparam logic [CSR_ADDR_W-1:0] DIVISOR_ADDR = {mdw_pkg::REG_DIVISOR, 3'b000};

   typedef struct packed {
      logic [WORD_BITS-1:0] limb;
      logic                 final_limb;
      logic                 negative;
   } limb_request_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] quotient;
      logic                 negative;
      logic [WORD_BITS-1:0] remainder;
      logic [WORD_BITS-1:0] modulus;
      logic                 last;
   } quotient_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_BITS-1:0]   req_tdata = '0;  // [63:0] limb
   logic                   req_tlast = 1'b0; // final_limb
   logic                   req_tuser = 1'b0; // negative
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [63:0] quotient_limb, [127:64] remainder_out, [191:128] modulus_out
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;        // last_out
   logic                   rsp_tuser;        // quotient_negative
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   multiword_divide_by_word dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the divider state
   logic [WORD_BITS-1:0] divisor_value = mdw_pkg::DIVISOR_RESET;
   logic [WORD_BITS-1:0] carried_remainder = '0;

   limb_request_type    pending_limbs[$];
   quotient_result_type expected_quotients[$];
   limb_request_type    driven_limb;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         quiet_cycles = 0;

   // restoring divide of (carried_remainder : limb), one quotient bit per limb bit
   function automatic logic [WORD_BITS-1:0] divide_limb(input logic [WORD_BITS-1:0] limb);
      logic [WORD_BITS-1:0] r;
      logic [WORD_BITS-1:0] q;
      logic                 carry;
      r = carried_remainder;
      q = '0;
      for (int i = LIMB_BITS - 1; i >= 0; i--) begin
         carry = r[WORD_BITS-1];
         r = {r[WORD_BITS-2:0], limb[i]};
         q = {q[WORD_BITS-2:0], 1'b0};
         if (carry || r >= divisor_value) begin
            r = r - divisor_value;
            q[0] = 1'b1;
         end
      end
      carried_remainder = r;
      return q & LIMB_MASK;
   endfunction

   function automatic void predict_quotient(input limb_request_type req);
      quotient_result_type e;
      e.quotient  = divide_limb(req.limb & LIMB_MASK);
      e.negative  = req.negative;
      e.last      = req.final_limb;
      e.remainder = '0;
      e.modulus   = '0;
      if (req.final_limb) begin
         e.remainder = carried_remainder;
         // floor modulus; wraps if the divisor changed mid-number
         e.modulus = (req.negative && carried_remainder != '0) ?
                     divisor_value - carried_remainder : carried_remainder;
         carried_remainder = '0;
      end
      expected_quotients.push_back(e);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_quotient(driven_limb);
         if (!req_tvalid || req_tready) begin
            if (pending_limbs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               driven_limb = pending_limbs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= driven_limb.limb;
               req_tlast  <= driven_limb.final_limb;
               req_tuser  <= driven_limb.negative;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      quotient_result_type e;
      quotient_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.quotient  = rsp_tdata[WORD_BITS-1:0];
            got.remainder = rsp_tdata[2*WORD_BITS-1:WORD_BITS];
            got.modulus   = rsp_tdata[3*WORD_BITS-1:2*WORD_BITS];
            got.negative  = rsp_tuser;
            got.last      = rsp_tlast;
            if (expected_quotients.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response: q=%h rem=%h mod=%h neg=%b last=%b",
                           got.quotient, got.remainder, got.modulus, got.negative,
                           got.last);
            end else begin
               e = expected_quotients.pop_front();
               if (got.quotient !== e.quotient || got.remainder !== e.remainder ||
                   got.modulus !== e.modulus || got.negative !== e.negative ||
                   got.last !== e.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("mismatch exp: q=%h rem=%h mod=%h neg=%b last=%b",
                              e.quotient, e.remainder, e.modulus, e.negative, e.last);
                     $display("         got: q=%h rem=%h mod=%h neg=%b last=%b",
                              got.quotient, got.remainder, got.modulus, got.negative,
                              got.last);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
         $display("multiword_divide_by_word test failed");
         $finish;
      end
   end

   function automatic void push_limb(input logic [WORD_BITS-1:0] limb, input logic fin,
                                     input logic neg);
      limb_request_type req;
      req.limb       = limb;
      req.final_limb = fin;
      req.negative   = neg;
      pending_limbs.push_back(req);
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [WORD_BITS-1:0] random_limb();
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 8) return '0;
      if (pick < 16) return ALL_ONES;
      if (pick < 30) return random_word() % divisor_value;
      if (pick < 40) return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1, 0);
      return random_word();
   endfunction

   // number lengths mostly short; the last number may stop mid-way so the
   // running remainder carries across the next divisor write
   task automatic push_random_numbers(input int unsigned count);
      int unsigned pushed;
      int unsigned len;
      int unsigned pick;
      logic        neg;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(99, 0);
         len = (pick < 70) ? $urandom_range(3, 1) :
               (pick < 95) ? $urandom_range(8, 4) : $urandom_range(16, 9);
         neg = 1'($urandom_range(1, 0));
         for (int k = 0; k < len && pushed < count; k++) begin
            push_limb(random_limb(), k == len - 1, neg);
            pushed++;
         end
      end
   endtask

   task automatic write_divisor(input logic [WORD_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DIVISOR_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      divisor_value = value;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_limbs.size() != 0 || req_tvalid || expected_quotients.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] divisor_for_phase(input int unsigned phase);
      logic [WORD_BITS-1:0] d;
      case (phase)
         0: d = ALL_ONES;
         1: d = WORD_BITS'(1);
         2: d = WORD_BITS'($urandom_range(255, 2));
         3: d = TOP_BIT;
         4: d = WORD_BITS'($urandom);
         5: d = random_word();
         6: d = ~TOP_BIT;
         7: d = random_word() | TOP_BIT;
         default: d = WORD_BITS'(2);
      endcase
      return (d == '0) ? WORD_BITS'(1) : d;
   endfunction

   initial begin
      send_idle_pct = 36;
      recv_idle_pct = 61;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset divisor of one: quotient equals the limb, remainder always zero
      push_limb('0, 1'b1, 1'b0);
      push_limb(ALL_ONES, 1'b1, 1'b1);
      push_limb(ALL_ONES, 1'b0, 1'b1);
      push_limb('0, 1'b1, 1'b1);
      wait_drained();

      // largest divisor: remainder top bit set drives the carry path
      write_divisor(ALL_ONES);
      push_limb(ALL_ONES - 1, 1'b0, 1'b1);
      push_limb(WORD_BITS'(5), 1'b1, 1'b1);
      push_limb(WORD_BITS'(123), 1'b1, 1'b0);
      push_limb('0, 1'b1, 1'b1);
      push_limb(ALL_ONES, 1'b0, 1'b0);
      push_limb(ALL_ONES, 1'b1, 1'b0);
      wait_drained();

      // number left open, then the divisor shrinks below the carried remainder
      write_divisor(TOP_BIT);
      push_limb(TOP_BIT + 7, 1'b1, 1'b1);
      push_limb(WORD_BITS'(5), 1'b0, 1'b0);
      wait_drained();
      write_divisor(WORD_BITS'(3));
      push_limb(ALL_ONES, 1'b0, 1'b1);
      push_limb(WORD_BITS'(9), 1'b1, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 9; phase++) begin
         send_idle_pct = (phase < 3) ? 36 : (phase < 6) ? 61 : 0;
         recv_idle_pct = (phase < 3) ? 61 : (phase < 6) ? 36 : 0;
         write_divisor(divisor_for_phase(phase));
         push_random_numbers(135);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_quotients.size() == 0) begin
         $display("multiword_divide_by_word test passed");
      end else begin
         $display("multiword_divide_by_word test failed");
      end
      $finish;
   end

endmodule
